[hw/rtl/swr_pkg.sv]
package swr_pkg;

    // Largest payload accepted by default.
    localparam int MAX_PAYLOAD_DEF = 255;

    // An ack may be sent at most this many times in a row.
    localparam logic [1:0] RETRY_LIMIT = 2'd2;

    // Configuration port.
    localparam int          ADDR_W          = 3;
    localparam int          DATA_W          = 32;
    localparam logic [15:0] BUFFER_SIZE_RST = 16'hFFFF;
    localparam logic        REG_BUFFER_SIZE = 1'b0;

    // Event kinds.
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_FRAME = 2'd1;
    localparam logic [1:0] CMD_SEND  = 2'd2;

    // Framing outcomes.
    localparam logic [1:0] FST_TIMEOUT  = 2'd0;
    localparam logic [1:0] FST_COMPLETE = 2'd2;

    // Packet kinds.
    localparam logic [2:0] KIND_START = 3'd2;
    localparam logic [2:0] KIND_END   = 3'd3;
    localparam logic [2:0] KIND_BAD   = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FRAME = 2'd1,
        PH_SEND  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        RSP_NONE = 2'd0,
        RSP_ACK  = 2'd1,
        RSP_BAD  = 2'd2
    } t_rsp;

    typedef enum logic [2:0] {
        ST_RUN      = 3'd0,
        ST_DONE     = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_MANY     = 3'd3,
        ST_NOSTORE  = 3'd4,
        ST_SENDFAIL = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] frame_status;
        logic       frame_valid;
        logic [2:0] packet_kind;
        logic [7:0] payload_length;
        logic       send_ok;
    } t_item;

    typedef struct packed {
        t_phase      phase;
        logic        started;
        logic        parity;
        logic        peer_bad;
        logic [1:0]  retry;
        logic [15:0] fill;
        t_rsp        pending;
        t_status     final_status;
    } t_state;

    typedef struct packed {
        t_rsp        send_response;
        logic        store_valid;
        logic [15:0] store_offset;
        logic [7:0]  store_length;
        t_status     status;
    } t_result;

endpackage

[hw/rtl/swr_apb_regs.sv]
module swr_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swr_pkg::ADDR_W-1:0]  paddr,
    input  logic [swr_pkg::DATA_W-1:0]  pwdata,
    output logic [swr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [15:0]                 o_buffer_size
);

    logic [15:0] r_buffer_size;
    logic        sel_buffer_size;

    // Register index is the word address.
    assign sel_buffer_size = (paddr[2] == swr_pkg::REG_BUFFER_SIZE);
    assign pready          = 1'b1;

    // Write at the end of the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= swr_pkg::BUFFER_SIZE_RST;
        end else if (psel && penable && pwrite && pready && sel_buffer_size) begin
            r_buffer_size <= pwdata[15:0];
        end
    end

    // Read back.
    always_comb begin
        prdata = '0;
        if (sel_buffer_size) begin
            prdata = {16'd0, r_buffer_size};
        end
    end

    assign o_buffer_size = r_buffer_size;

endmodule

[hw/rtl/swr_engine.sv]
module swr_engine #(
    parameter int MAX_PAYLOAD = swr_pkg::MAX_PAYLOAD_DEF
) (
    input  swr_pkg::t_item   i_item,
    input  swr_pkg::t_state  i_state,
    input  logic [15:0]      i_buffer_size,
    output swr_pkg::t_state  o_state,
    output swr_pkg::t_result o_result
);

    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

    logic [16:0] fill_sum;
    logic        len_bad;

    assign fill_sum = {1'b0, i_state.fill} + {9'd0, i_item.payload_length};
    assign len_bad  = ({8'd0, i_item.payload_length} > MaxLen);

    // One event: decide the state change, then pick the response to send.
    always_comb begin
        logic do_answer;
        do_answer = 1'b0;
        o_state   = i_state;
        o_result  = '{send_response: swr_pkg::RSP_NONE, store_valid: 1'b0,
                      store_offset: 16'd0, store_length: 8'd0,
                      status: swr_pkg::ST_RUN};

        if (i_item.cmd == swr_pkg::CMD_BEGIN) begin
            o_state.started      = 1'b0;
            o_state.parity       = 1'b0;
            o_state.peer_bad     = 1'b0;
            o_state.retry        = 2'd0;
            o_state.fill         = 16'd0;
            o_state.pending      = swr_pkg::RSP_NONE;
            o_state.final_status = swr_pkg::ST_RUN;
            o_state.phase        = swr_pkg::PH_FRAME;
        end else if (i_item.cmd == swr_pkg::CMD_FRAME &&
                     i_state.phase == swr_pkg::PH_FRAME) begin
            if (i_item.frame_status == swr_pkg::FST_TIMEOUT) begin
                o_state.final_status = swr_pkg::ST_TIMEOUT;
                o_state.phase        = swr_pkg::PH_IDLE;
            end else if (i_item.frame_status != swr_pkg::FST_COMPLETE ||
                         !i_item.frame_valid || len_bad) begin
                // Corrupt framing, failed check or oversized payload.
                o_state.pending = swr_pkg::RSP_BAD;
                do_answer       = 1'b1;
            end else if (i_item.packet_kind == swr_pkg::KIND_END) begin
                o_state.final_status = swr_pkg::ST_DONE;
                o_state.phase        = swr_pkg::PH_IDLE;
            end else if (i_item.packet_kind == swr_pkg::KIND_START) begin
                o_state.pending = i_state.started ? swr_pkg::RSP_BAD : swr_pkg::RSP_ACK;
                o_state.started = 1'b1;
                do_answer       = 1'b1;
            end else if (!i_state.started) begin
                o_state.pending = swr_pkg::RSP_BAD;
                do_answer       = 1'b1;
            end else if (i_item.packet_kind == swr_pkg::KIND_BAD) begin
                // The first bad report from the peer resends the last response.
                if (!i_state.peer_bad) begin
                    o_state.peer_bad = 1'b1;
                    do_answer        = 1'b1;
                end else begin
                    o_state.final_status = swr_pkg::ST_MANY;
                    o_state.phase        = swr_pkg::PH_IDLE;
                end
            end else if (i_item.packet_kind != {2'd0, i_state.parity}) begin
                // Duplicate or unknown kind: ack without storing.
                o_state.pending = swr_pkg::RSP_ACK;
                do_answer       = 1'b1;
            end else begin
                o_state.parity = ~i_state.parity;
                if (fill_sum > {1'b0, i_buffer_size}) begin
                    o_state.final_status = swr_pkg::ST_NOSTORE;
                    o_state.phase        = swr_pkg::PH_IDLE;
                end else begin
                    o_result.store_valid  = 1'b1;
                    o_result.store_offset = i_state.fill;
                    o_result.store_length = i_item.payload_length;
                    o_state.fill          = fill_sum[15:0];
                    o_state.pending       = swr_pkg::RSP_ACK;
                    do_answer             = 1'b1;
                end
            end
        end else if (i_item.cmd == swr_pkg::CMD_SEND &&
                     i_state.phase == swr_pkg::PH_SEND) begin
            if (i_item.send_ok) begin
                if (i_state.pending == swr_pkg::RSP_ACK) begin
                    o_state.retry = 2'd0;
                end
                o_state.phase = swr_pkg::PH_FRAME;
            end else if (i_state.pending == swr_pkg::RSP_ACK && i_state.retry == 2'd0) begin
                o_state.retry          = 2'd1;
                o_result.send_response = swr_pkg::RSP_ACK;
            end else begin
                o_state.final_status = swr_pkg::ST_SENDFAIL;
                o_state.phase        = swr_pkg::PH_IDLE;
            end
        end

        // Response choice: ack while retries remain, else one bad, else give up.
        if (do_answer) begin
            if (o_state.pending == swr_pkg::RSP_ACK && o_state.retry < swr_pkg::RETRY_LIMIT) begin
                o_state.phase          = swr_pkg::PH_SEND;
                o_result.send_response = swr_pkg::RSP_ACK;
            end else if (o_state.retry == 2'd0) begin
                o_state.pending        = swr_pkg::RSP_BAD;
                o_state.retry          = 2'd1;
                o_state.phase          = swr_pkg::PH_SEND;
                o_result.send_response = swr_pkg::RSP_BAD;
            end else begin
                o_state.final_status = swr_pkg::ST_MANY;
                o_state.phase        = swr_pkg::PH_IDLE;
            end
        end

        o_result.status = o_state.final_status;
    end

endmodule

[hw/rtl/stop_and_wait_receiver_unit.sv]
// Stop-and-wait receiver: every accepted event item (begin, frame outcome or
// send result) gives exactly one result item, through the input and result
// registers, with the response to transmit, the store offset and length for
// the payload copier, and the session status. A new item is taken in every
// cycle unless stalled; the rate is set by the single pass through the
// decision logic between the input register and the result register, which
// also holds the session state. The buffer_size register sits at byte address
// 0 of the APB port and should be written only while no item is in flight.
module stop_and_wait_receiver_unit #(
    parameter int MAX_PAYLOAD = swr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swr_pkg::ADDR_W-1:0]  paddr,
    input  logic [swr_pkg::DATA_W-1:0]  pwdata,
    output logic [swr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Event items
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_cmd,
    input  logic [1:0]                  i_frame_status,
    input  logic                        i_frame_valid,
    input  logic [2:0]                  i_packet_kind,
    input  logic [7:0]                  i_payload_length,
    input  logic                        i_send_ok,
    // Result items
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_send_response,
    output logic                        o_store_valid,
    output logic [15:0]                 o_store_offset,
    output logic [7:0]                  o_store_length,
    output logic [2:0]                  o_status
);

    logic [15:0]      buffer_size;
    logic             r_in_valid;
    swr_pkg::t_item   r_item;
    swr_pkg::t_state  r_state;
    swr_pkg::t_state  n_state;
    logic             r_out_valid;
    swr_pkg::t_result r_result;
    swr_pkg::t_result n_result;
    logic             advance;
    logic             take;

    swr_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_buffer_size (buffer_size)
    );

    swr_engine #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_engine (
        .i_item        (r_item),
        .i_state       (r_state),
        .i_buffer_size (buffer_size),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // The pipeline moves whenever the result register is free or being taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign take       = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= '{cmd: i_cmd, frame_status: i_frame_status,
                        frame_valid: i_frame_valid, packet_kind: i_packet_kind,
                        payload_length: i_payload_length, send_ok: i_send_ok};
        end
    end

    // Session state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid          <= 1'b0;
            r_state.phase        <= swr_pkg::PH_IDLE;
            r_state.started      <= 1'b0;
            r_state.parity       <= 1'b0;
            r_state.peer_bad     <= 1'b0;
            r_state.retry        <= 2'd0;
            r_state.fill         <= 16'd0;
            r_state.pending      <= swr_pkg::RSP_NONE;
            r_state.final_status <= swr_pkg::ST_RUN;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_send_response = r_result.send_response;
    assign o_store_valid   = r_result.store_valid;
    assign o_store_offset  = r_result.store_offset;
    assign o_store_length  = r_result.store_length;
    assign o_status        = r_result.status;

endmodule
